>>> rtl/core/hev_pkg.sv
// Shared types, constants and entity tables for the HTML escaper with UTF-8 check.
// No dependencies; imported by the front, queue, back, top-level and bench files.
`default_nettype none

package hev_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int CHARS_W = 16;
    localparam int TOTAL_W = 20;

    localparam logic [CHARS_W-1:0] MAX_CHARS_RST = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 20'hFFFFF;

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_BYTE   = 2'd0;
    localparam logic [1:0] CMD_ENTITY = 2'd1;
    localparam logic [1:0] CMD_MARKER = 2'd2;

    // Entity codes, carried in the low bits of the command data
    localparam logic [2:0] ENT_LT   = 3'd0;
    localparam logic [2:0] ENT_GT   = 3'd1;
    localparam logic [2:0] ENT_AMP  = 3'd2;
    localparam logic [2:0] ENT_QUOT = 3'd3;
    localparam logic [2:0] ENT_APOS = 3'd4;

    // Characters that need escaping
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // UTF-8 lead and continuation masks
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       status;
        logic       last;
    } cmd_t;

    // Number of output bytes of an entity
    function automatic logic [2:0] entity_len(input logic [2:0] code);
        logic [2:0] len;
        unique case (code)
            ENT_LT:   len = 3'd4;
            ENT_GT:   len = 3'd4;
            ENT_AMP:  len = 3'd5;
            ENT_QUOT: len = 3'd6;
            ENT_APOS: len = 3'd5;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte at position pos of an entity
    function automatic logic [7:0] entity_char(input logic [2:0] code, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (code)
            ENT_LT:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h26; // &
                    3'd1:    ch = 8'h6C; // l
                    3'd2:    ch = 8'h74; // t
                    3'd3:    ch = 8'h3B; // ;
                    default: ch = 8'h00;
                endcase
            end
            ENT_GT:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h26;
                    3'd1:    ch = 8'h67; // g
                    3'd2:    ch = 8'h74;
                    3'd3:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            ENT_AMP:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h26;
                    3'd1:    ch = 8'h61; // a
                    3'd2:    ch = 8'h6D; // m
                    3'd3:    ch = 8'h70; // p
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            ENT_QUOT:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h26;
                    3'd1:    ch = 8'h71; // q
                    3'd2:    ch = 8'h75; // u
                    3'd3:    ch = 8'h6F; // o
                    3'd4:    ch = 8'h74;
                    3'd5:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            ENT_APOS:
            begin
                unique case (pos)
                    3'd0:    ch = 8'h26;
                    3'd1:    ch = 8'h23; // #
                    3'd2:    ch = 8'h33; // 3
                    3'd3:    ch = 8'h39; // 9
                    3'd4:    ch = 8'h3B;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hev_if.sv
// Handshake channel interfaces: input bytes, result items, configuration writes.
// Field widths are written as literals here; this file does not depend on hev_pkg.
`default_nettype none

interface hev_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface hev_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_out;
    logic        status;
    logic        string_done;
    logic [19:0] total_bytes;

    modport source (output valid, output out_byte, output byte_valid, output last_out,
                    output status, output string_done, output total_bytes, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last_out,
                    input status, input string_done, input total_bytes, output ready);
endinterface

interface hev_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_chars;

    modport source (output valid, output max_chars, input ready);
    modport sink   (input valid, input max_chars, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hev_front.sv
// Front end: accepts input bytes, checks UTF-8, counts characters, issues commands.
// Depends on hev_pkg and the channel interfaces in hev_if.sv.
`default_nettype none

module hev_front (
    input  wire              clk,
    input  wire              rst_n,
    hev_in_if.sink           in_ch,
    hev_cfg_if.sink          cfg,
    input  wire              q_full,
    output logic             q_push,
    output hev_pkg::cmd_t    q_cmd
);
    import hev_pkg::*;

    logic                in_seq_reg, in_seq_next;
    logic [1:0]          cont_reg, cont_next;
    logic [CHARS_W-1:0]  char_reg, char_next;
    logic                abort_reg, abort_next;
    logic [CHARS_W-1:0]  max_chars_reg;

    logic       accept;
    logic       produced;
    logic [7:0] c;
    cmd_t       cmd;

    assign in_ch.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.in_byte;

    // Classify the byte and work out the next string state
    always_comb
    begin
        in_seq_next = in_seq_reg;
        cont_next   = cont_reg;
        char_next   = char_reg;
        abort_next  = abort_reg;
        produced    = 1'b0;
        cmd.kind    = CMD_MARKER;
        cmd.data    = 8'h00;
        cmd.status  = 1'b0;
        cmd.last    = in_ch.last_in;

        if (!abort_reg && (char_reg < max_chars_reg))
        begin
            produced = 1'b1;
            if (in_seq_reg)
            begin
                if ((c & MASK_CONT) != PAT_CONT)
                begin
                    abort_next = 1'b1;
                    cmd.status = 1'b1;
                end
                else
                begin
                    cmd.kind  = CMD_BYTE;
                    cmd.data  = c;
                    cont_next = cont_reg - 2'd1;
                    if (cont_reg == 2'd1)
                    begin
                        in_seq_next = 1'b0;
                        char_next   = char_reg + 16'd1;
                    end
                end
            end
            else if (c == CH_LT)
            begin
                cmd.kind  = CMD_ENTITY;
                cmd.data  = {5'd0, ENT_LT};
                char_next = char_reg + 16'd1;
            end
            else if (c == CH_GT)
            begin
                cmd.kind  = CMD_ENTITY;
                cmd.data  = {5'd0, ENT_GT};
                char_next = char_reg + 16'd1;
            end
            else if (c == CH_AMP)
            begin
                cmd.kind  = CMD_ENTITY;
                cmd.data  = {5'd0, ENT_AMP};
                char_next = char_reg + 16'd1;
            end
            else if (c == CH_QUOT)
            begin
                cmd.kind  = CMD_ENTITY;
                cmd.data  = {5'd0, ENT_QUOT};
                char_next = char_reg + 16'd1;
            end
            else if (c == CH_APOS)
            begin
                cmd.kind  = CMD_ENTITY;
                cmd.data  = {5'd0, ENT_APOS};
                char_next = char_reg + 16'd1;
            end
            else if (!c[7])
            begin
                cmd.kind  = CMD_BYTE;
                cmd.data  = c;
                char_next = char_reg + 16'd1;
            end
            else if ((c & MASK_LEAD2) == PAT_LEAD2)
            begin
                cmd.kind    = CMD_BYTE;
                cmd.data    = c;
                cont_next   = 2'd1;
                in_seq_next = 1'b1;
            end
            else if ((c & MASK_LEAD3) == PAT_LEAD3)
            begin
                cmd.kind    = CMD_BYTE;
                cmd.data    = c;
                cont_next   = 2'd2;
                in_seq_next = 1'b1;
            end
            else if ((c & MASK_LEAD4) == PAT_LEAD4)
            begin
                cmd.kind    = CMD_BYTE;
                cmd.data    = c;
                cont_next   = 2'd3;
                in_seq_next = 1'b1;
            end
            else
            begin
                abort_next = 1'b1;
                cmd.status = 1'b1;
            end
        end

        // Dropped last byte still closes the string with a marker
        if (!produced)
        begin
            cmd.status = abort_next;
        end

        // Clear string state after its last byte
        if (in_ch.last_in)
        begin
            in_seq_next = 1'b0;
            cont_next   = 2'd0;
            char_next   = '0;
            abort_next  = 1'b0;
        end
    end

    assign q_push = accept && (produced || in_ch.last_in);
    assign q_cmd  = cmd;

    // Hold string state and the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg    <= 1'b0;
            cont_reg      <= 2'd0;
            char_reg      <= '0;
            abort_reg     <= 1'b0;
            max_chars_reg <= MAX_CHARS_RST;
        end
        else
        begin
            if (accept)
            begin
                in_seq_reg <= in_seq_next;
                cont_reg   <= cont_next;
                char_reg   <= char_next;
                abort_reg  <= abort_next;
            end
            if (cfg.valid)
            begin
                max_chars_reg <= cfg.max_chars;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/hev_queue.sv
// Command queue between front and back end, flip-flop storage.
// Depends on hev_pkg for the command type.
`default_nettype none

module hev_queue #(
    parameter int DEPTH = hev_pkg::QUEUE_DEPTH_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  hev_pkg::cmd_t    push_cmd,
    output logic             full,
    input  wire              pop,
    output logic             head_valid,
    output hev_pkg::cmd_t    head_cmd
);
    import hev_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow queue");

endmodule

`default_nettype wire

>>> rtl/core/hev_back.sv
// Back end: expands commands into result bytes, keeps the byte total, output register.
// Depends on hev_pkg (command type, entity tables) and hev_if.sv.
`default_nettype none

module hev_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_valid,
    input  hev_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    hev_out_if.source        out_ch
);
    import hev_pkg::*;

    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                byte_valid_reg;
    logic                last_out_reg;
    logic                status_reg;
    logic                done_reg;
    logic [TOTAL_W-1:0]  total_out_reg;
    logic [2:0]          sub_reg, sub_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;

    logic               out_free;
    logic               emit;
    logic               is_final;
    logic [7:0]         res_byte;
    logic               res_valid;
    logic               res_status;
    logic [TOTAL_W-1:0] res_total;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign emit     = out_free && q_valid;

    // Build the result for the current command step
    always_comb
    begin
        is_final   = 1'b1;
        res_byte   = 8'h00;
        res_valid  = 1'b0;
        res_status = 1'b0;
        unique case (q_cmd.kind)
            CMD_BYTE:
            begin
                res_byte  = q_cmd.data;
                res_valid = 1'b1;
            end
            CMD_ENTITY:
            begin
                res_byte  = entity_char(q_cmd.data[2:0], sub_reg);
                res_valid = 1'b1;
                is_final  = (sub_reg == 3'(entity_len(q_cmd.data[2:0]) - 3'd1));
            end
            default:
            begin
                res_status = q_cmd.status;
            end
        endcase
        res_total = (res_valid && (total_reg != TOTAL_MAX)) ? total_reg + 1'b1 : total_reg;
        sub_next  = is_final ? 3'd0 : sub_reg + 3'd1;
        total_next = (is_final && q_cmd.last) ? '0 : res_total;
    end

    assign q_pop = emit && is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 3'd0;
            total_reg     <= '0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= q_valid;
            end
            if (emit)
            begin
                sub_reg   <= sub_next;
                total_reg <= total_next;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_valid;
            last_out_reg   <= is_final;
            status_reg     <= res_status;
            done_reg       <= is_final && q_cmd.last;
            total_out_reg  <= res_total;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.byte_valid  = byte_valid_reg;
    assign out_ch.last_out    = last_out_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.string_done = done_reg;
    assign out_ch.total_bytes = total_out_reg;

    a_sub_in_entity: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg != 3'd0) |-> (q_valid && (q_cmd.kind == CMD_ENTITY)))
        else $error("entity step counter set without an entity at the head");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_out_reg)
        else $error("string end on a result that is not the last of its input");

    a_total_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_final && q_cmd.last) |=> (total_reg == '0))
        else $error("byte total not cleared after string end");

endmodule

`default_nettype wire

>>> rtl/core/html_escape_utf8_validator.sv
// HTML escaper with UTF-8 check. An accepted byte's command is written into the command
// queue, and the back end then loads its first result into the output register. Throughput:
// one input byte per cycle for plain bytes while the queue is not full; an entity expands
// to 4 to 6 result bytes, absorbed by the QUEUE_DEPTH-entry command queue before input
// ready drops. Output stage accepts a new result in the cycle its previous one is taken.
// Reset clears all string state and the queue and sets max_chars to 65535.
`default_nettype none

module html_escape_utf8_validator #(
    parameter int QUEUE_DEPTH = hev_pkg::QUEUE_DEPTH_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    hev_in_if.sink     in_ch,
    hev_cfg_if.sink    cfg,
    hev_out_if.source  out_ch
);
    import hev_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head;

    // Classify and check input bytes
    hev_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // Decouple front and back
    hev_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Expand commands into result bytes
    hev_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_head),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for html_escape_utf8_validator: directed and random strings, checked word by word.
// Depends on hev_pkg (rtl/core/hev_pkg.sv) and the channel interfaces in rtl/core/hev_if.sv.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hev_pkg::*;

    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_BAD     = 1'b1;
    localparam int   DRAIN_CYCLES = 10;
    localparam int   HOLDOFF_LEN  = 120;
    localparam int   IDLE_PCT     = 15;
    localparam int   SHOW_ERRORS  = 10;

    typedef enum int unsigned {TEXT_CLEAN, TEXT_BROKEN, TEXT_TRUNC, TEXT_NOISE} text_kind_e;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_out;
        logic        status;
        logic        string_done;
        logic [19:0] total_bytes;
    } esc_word_t;

    logic clk;
    logic rst_n;

    hev_in_if  in_ch();
    hev_cfg_if cfg_ch();
    hev_out_if out_ch();

    html_escape_utf8_validator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_ch),
        .out_ch (out_ch)
    );

    // Escaper state as the block should hold it
    logic [15:0] limit_chars;
    logic        seq_open;
    logic [1:0]  cont_left;
    logic [15:0] chars_seen;
    logic        str_aborted;
    logic [19:0] out_total;

    esc_word_t   step_words[$];
    esc_word_t   expected_words[$];
    logic [7:0]  text_bytes[$];

    int unsigned error_count;
    bit          idle_on;
    bit          holdoff_go;
    int unsigned holdoff_left;
    esc_word_t   got_word;
    esc_word_t   want_word;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Escaper prediction
    function automatic void clear_text_state();
        seq_open    = 1'b0;
        cont_left   = 2'd0;
        chars_seen  = 16'd0;
        str_aborted = 1'b0;
        out_total   = 20'd0;
    endfunction

    function automatic void stage_word(input logic [7:0] data, input logic v, input logic st);
        esc_word_t w;
        if (v && out_total != TOTAL_MAX)
            out_total++;
        w.out_byte    = data;
        w.byte_valid  = v;
        w.last_out    = 1'b0;
        w.status      = st;
        w.string_done = 1'b0;
        w.total_bytes = out_total;
        step_words.push_back(w);
    endfunction

    function automatic void stage_entity(input string txt);
        for (int i = 0; i < txt.len(); i++)
            stage_word(txt[i], 1'b1, STAT_OK);
        chars_seen++;
    endfunction

    function automatic void stage_lead(input logic [7:0] c, input logic [1:0] n_cont);
        stage_word(c, 1'b1, STAT_OK);
        cont_left = n_cont;
        seq_open  = 1'b1;
    endfunction

    function automatic void predict_escape(input logic [7:0] c, input logic lst);
        step_words.delete();
        if (!str_aborted && chars_seen < limit_chars)
        begin
            if (seq_open)
            begin
                if ((c & MASK_CONT) != PAT_CONT)
                begin
                    str_aborted = 1'b1;
                    stage_word(8'h00, 1'b0, STAT_BAD);
                end
                else
                begin
                    stage_word(c, 1'b1, STAT_OK);
                    cont_left--;
                    if (cont_left == 2'd0)
                    begin
                        seq_open = 1'b0;
                        chars_seen++;
                    end
                end
            end
            else
            begin
                case (c)
                    CH_LT:   stage_entity("&lt;");
                    CH_GT:   stage_entity("&gt;");
                    CH_AMP:  stage_entity("&amp;");
                    CH_QUOT: stage_entity("&quot;");
                    CH_APOS: stage_entity("&#39;");
                    default:
                    begin
                        if (!c[7])
                        begin
                            stage_word(c, 1'b1, STAT_OK);
                            chars_seen++;
                        end
                        else if ((c & MASK_LEAD2) == PAT_LEAD2)
                            stage_lead(c, 2'd1);
                        else if ((c & MASK_LEAD3) == PAT_LEAD3)
                            stage_lead(c, 2'd2);
                        else if ((c & MASK_LEAD4) == PAT_LEAD4)
                            stage_lead(c, 2'd3);
                        else
                        begin
                            str_aborted = 1'b1;
                            stage_word(8'h00, 1'b0, STAT_BAD);
                        end
                    end
                endcase
            end
        end

        // Dropped last byte still closes the string with a marker
        if (lst && step_words.size() == 0)
            stage_word(8'h00, 1'b0, str_aborted);

        if (step_words.size() != 0)
        begin
            step_words[step_words.size()-1].last_out    = 1'b1;
            step_words[step_words.size()-1].string_done = lst;
        end
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);

        if (lst)
            clear_text_state();
    endfunction

    // Text generation
    function automatic logic [7:0] pick_special();
        logic [7:0] c;
        case ($urandom_range(4))
            0:       c = CH_LT;
            1:       c = CH_GT;
            2:       c = CH_AMP;
            3:       c = CH_QUOT;
            default: c = CH_APOS;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cont_byte();
        return PAT_CONT | 8'($urandom_range(63));
    endfunction

    function automatic void append_char();
        int unsigned n_cont;
        n_cont = 0;
        case ($urandom_range(9))
            0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(127)));
            4, 5:       text_bytes.push_back(pick_special());
            6:
            begin
                text_bytes.push_back(PAT_LEAD2 | 8'($urandom_range(31)));
                n_cont = 1;
            end
            7:
            begin
                text_bytes.push_back(PAT_LEAD3 | 8'($urandom_range(15)));
                n_cont = 2;
            end
            8:
            begin
                text_bytes.push_back(PAT_LEAD4 | 8'($urandom_range(7)));
                n_cont = 3;
            end
            default:    text_bytes.push_back(8'($urandom_range(126, 32)));
        endcase
        repeat (n_cont)
            text_bytes.push_back(cont_byte());
    endfunction

    function automatic void fill_text(input text_kind_e kind);
        int unsigned n_chars;
        int unsigned idx;
        text_bytes.delete();
        n_chars = $urandom_range(10, 1);
        if (kind == TEXT_NOISE)
        begin
            repeat (n_chars)
                text_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        repeat (n_chars)
            append_char();
        case (kind)
            TEXT_BROKEN:
            begin
                // overwrite one byte, or slip in a stray continuation or bad lead
                idx = $urandom_range(text_bytes.size() - 1);
                if ($urandom_range(1))
                    text_bytes[idx] = 8'($urandom_range(255));
                else if ($urandom_range(1))
                    text_bytes.insert(idx, cont_byte());
                else
                    text_bytes.insert(idx, 8'($urandom_range(8'hFF, 8'hF8)));
            end
            TEXT_TRUNC:
            begin
                // end the string inside a multi-byte character
                text_bytes.push_back(PAT_LEAD3 | 8'($urandom_range(15)));
                if ($urandom_range(1))
                    text_bytes.push_back(cont_byte());
            end
            default: ;
        endcase
    endfunction

    // Input side: one word per handshake
    task automatic send_byte(input logic [7:0] data, input logic lst);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= data;
        in_ch.last_in <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_escape(data, lst);
        @(negedge clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned roll;
        sent = 0;
        while (sent < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                fill_text(TEXT_CLEAN);
            else if (roll < 85)
                fill_text(TEXT_BROKEN);
            else if (roll < 93)
                fill_text(TEXT_TRUNC);
            else
                fill_text(TEXT_NOISE);
            send_text();
            sent += text_bytes.size();
        end
    endtask

    // Hold until every expected word is out and the pipe has drained
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_max_chars(input logic [15:0] value);
        wait_idle();
        cfg_ch.max_chars <= value;
        cfg_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        limit_chars = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Test: every escaped character, ASCII extremes, 2- to 4-byte characters
    task automatic test_escapes();
        send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_QUOT, 1'b0);
        send_byte(CH_APOS, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Test: bad lead, bad continuation, dropped bytes after abort, truncated end
    task automatic test_bad_utf8();
        send_byte(8'h41, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h42, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(CH_LT, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
    endtask

    // Test: random strings at default and at small, zero and random limits
    task automatic test_char_limits();
        run_random(80);
        write_max_chars(16'd0);
        run_random(30);
        write_max_chars(16'd1);
        run_random(40);
        write_max_chars(16'd3);
        run_random(50);
        write_max_chars(16'($urandom_range(12, 2)));
        run_random(50);
        write_max_chars(16'($urandom_range(65535)));
        run_random(40);
        write_max_chars(MAX_CHARS_RST);
    endtask

    // Test: back-to-back words on both sides
    task automatic test_no_idle();
        idle_on = 1'b0;
        run_random(60);
        idle_on = 1'b1;
    endtask

    // Test: long output stall while input keeps offering, so input ready drops
    task automatic test_output_holdoff();
        holdoff_go = 1'b1;
        run_random(40);
    endtask

    // Output side: random stalls plus the requested hold-off
    always @(negedge clk)
    begin
        if (holdoff_go)
        begin
            holdoff_left = HOLDOFF_LEN;
            holdoff_go   = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(99) < IDLE_PCT)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= 1'b1;
    end

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= SHOW_ERRORS)
            $display("%s", msg);
    endtask

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got_word.out_byte    = out_ch.out_byte;
            got_word.byte_valid  = out_ch.byte_valid;
            got_word.last_out    = out_ch.last_out;
            got_word.status      = out_ch.status;
            got_word.string_done = out_ch.string_done;
            got_word.total_bytes = out_ch.total_bytes;
            if (expected_words.size() == 0)
                log_error($sformatf("%0t: unexpected word byte %02h valid %b status %b",
                                    $realtime, got_word.out_byte, got_word.byte_valid,
                                    got_word.status));
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word !== want_word)
                    log_error($sformatf({"%0t: mismatch exp/act byte %02h/%02h valid %b/%b",
                                         " last %b/%b status %b/%b done %b/%b total %0d/%0d"},
                                        $realtime,
                                        want_word.out_byte, got_word.out_byte,
                                        want_word.byte_valid, got_word.byte_valid,
                                        want_word.last_out, got_word.last_out,
                                        want_word.status, got_word.status,
                                        want_word.string_done, got_word.string_done,
                                        want_word.total_bytes, got_word.total_bytes));
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'h00;
        in_ch.last_in    = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.max_chars = 16'h0000;
        out_ch.ready     = 1'b0;
        idle_on          = 1'b1;
        holdoff_go       = 1'b0;
        holdoff_left     = 0;
        error_count      = 0;
        limit_chars      = MAX_CHARS_RST;
        clear_text_state();

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_escapes();
        test_bad_utf8();
        test_char_limits();
        test_no_idle();
        test_output_holdoff();

        wait_idle();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/hev_pkg.sv
rtl/core/hev_if.sv
rtl/core/hev_front.sv
rtl/core/hev_queue.sv
rtl/core/hev_back.sv
rtl/core/html_escape_utf8_validator.sv
bench/tb_top.sv
